// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the geometry decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define VTGD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge of clk, reset included.
`define VTGD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/vtgd_pkg.sv
// ----------------------------------------------------------------------------
// vtgd_pkg
// Types, codes and helpers shared by the vector tile geometry decoder.
// ----------------------------------------------------------------------------
package vtgd_pkg;

    localparam int AREA_BITS_DEF = 64;

    // Result queue depth; must be a power of two and at least four.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_TUSER_W = 2;

    // Input opcodes.
    localparam logic OP_WORD = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Geometry command ids.
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
    localparam logic [2:0] CMD_LINE_TO    = 3'd2;
    localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

    localparam logic [1:0] FTYPE_LINE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_RING  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Operations on the running shoelace sum.
    localparam logic [1:0] AREA_NONE  = 2'd0;
    localparam logic [1:0] AREA_CLEAR = 2'd1;
    localparam logic [1:0] AREA_ADD   = 2'd2;
    localparam logic [1:0] AREA_CLOSE = 2'd3;

    // Work handed from the decoder to the area stage.
    typedef struct packed {
        logic        has_ring;
        logic        ring_close;   // exterior comes from the closed area sum
        logic [31:0] ring_start;
        logic [31:0] ring_points;
        logic        has_point;
        logic [31:0] px;
        logic [31:0] py;
        logic        has_end;
        logic [1:0]  area_op;
        logic [31:0] a0;           // cross term a0*b0 - a1*b1
        logic [31:0] b0;
        logic [31:0] a1;
        logic [31:0] b1;
    } job_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [31:0]        ring_start;
        logic [31:0]        ring_points;
        logic               exterior;
        logic               last;
    } res_t;

    function automatic logic [31:0] unzig(input logic [31:0] w);
        unzig = {1'b0, w[31:1]} ^ {32{w[0]}};
    endfunction

endpackage

// File: design/vtgd_decode.sv
// ----------------------------------------------------------------------------
// vtgd_decode
// Command and delta decoding, cursor and ring bookkeeping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtgd_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                accept,
    input  logic                opcode,
    input  logic [31:0]         word,
    input  logic [1:0]          ftype,
    output logic                job_valid,
    output vtgd_pkg::job_t      job
);

    logic [31:0]    cursor_x_reg, cursor_x_next;
    logic [31:0]    cursor_y_reg, cursor_y_next;
    logic [2:0]     active_reg, active_next;
    logic [28:0]    pairs_left_reg, pairs_left_next;
    logic           have_x_reg, have_x_next;
    logic [31:0]    held_x_reg, held_x_next;
    logic [31:0]    first_index_reg, first_index_next;
    logic [31:0]    ring_count_reg, ring_count_next;
    logic [31:0]    first_x_reg, first_x_next;
    logic [31:0]    first_y_reg, first_y_next;
    logic           halted_reg, halted_next;
    logic [31:0]    point_counter_reg, point_counter_next;
    logic           job_valid_reg;
    vtgd_pkg::job_t job_reg, job_next;

    logic [31:0] nx;
    logic [31:0] ny;
    logic [2:0]  cmd_id;
    logic [28:0] cmd_cnt;
    logic        line_flush;
    logic [31:0] rc_eff;

    always_comb
    begin
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        active_next        = active_reg;
        pairs_left_next    = pairs_left_reg;
        have_x_next        = have_x_reg;
        held_x_next        = held_x_reg;
        first_index_next   = first_index_reg;
        ring_count_next    = ring_count_reg;
        first_x_next       = first_x_reg;
        first_y_next       = first_y_reg;
        halted_next        = halted_reg;
        point_counter_next = point_counter_reg;
        job_next           = '0;

        nx         = cursor_x_reg + vtgd_pkg::unzig(held_x_reg);
        ny         = cursor_y_reg + vtgd_pkg::unzig(word);
        cmd_id     = word[2:0];
        cmd_cnt    = word[31:3];
        line_flush = (ftype == vtgd_pkg::FTYPE_LINE) && (ring_count_reg >= 32'd2);
        rc_eff     = ring_count_reg;

        if (accept)
        begin
            if (opcode == vtgd_pkg::OP_END)
            begin
                job_next.has_ring    = line_flush;
                job_next.ring_start  = first_index_reg;
                job_next.ring_points = ring_count_reg;
                job_next.has_end     = 1'b1;
                job_next.area_op     = vtgd_pkg::AREA_CLEAR;
                cursor_x_next    = '0;
                cursor_y_next    = '0;
                active_next      = vtgd_pkg::CMD_NONE;
                pairs_left_next  = '0;
                have_x_next      = 1'b0;
                held_x_next      = '0;
                first_index_next = '0;
                ring_count_next  = '0;
                first_x_next     = '0;
                first_y_next     = '0;
                halted_next      = 1'b0;
            end
            else if (halted_reg)
            begin
                job_next = '0;
            end
            else if ((active_reg inside {vtgd_pkg::CMD_MOVE_TO, vtgd_pkg::CMD_LINE_TO})
                     && (pairs_left_reg != '0))
            begin
                if (!have_x_reg)
                begin
                    held_x_next = word;
                    have_x_next = 1'b1;
                end
                else
                begin
                    cursor_x_next = nx;
                    cursor_y_next = ny;
                    have_x_next   = 1'b0;
                    // A MoveTo always opens a new ring; a line ring is flushed first.
                    if (active_reg == vtgd_pkg::CMD_MOVE_TO)
                    begin
                        job_next.has_ring    = line_flush;
                        job_next.ring_start  = first_index_reg;
                        job_next.ring_points = ring_count_reg;
                        rc_eff               = '0;
                    end
                    if (rc_eff == '0)
                    begin
                        first_index_next = point_counter_reg;
                        first_x_next     = nx;
                        first_y_next     = ny;
                        job_next.area_op = vtgd_pkg::AREA_CLEAR;
                    end
                    else
                    begin
                        job_next.area_op = vtgd_pkg::AREA_ADD;
                        job_next.a0      = cursor_x_reg;
                        job_next.b0      = ny;
                        job_next.a1      = nx;
                        job_next.b1      = cursor_y_reg;
                    end
                    job_next.has_point = 1'b1;
                    job_next.px        = nx;
                    job_next.py        = ny;
                    point_counter_next = point_counter_reg + 32'd1;
                    ring_count_next    = (rc_eff == '1) ? rc_eff : rc_eff + 32'd1;
                    pairs_left_next    = pairs_left_reg - 29'd1;
                    if (pairs_left_reg == 29'd1)
                    begin
                        active_next = vtgd_pkg::CMD_NONE;
                    end
                end
            end
            else
            begin
                have_x_next = 1'b0;
                if (cmd_id inside {vtgd_pkg::CMD_MOVE_TO, vtgd_pkg::CMD_LINE_TO})
                begin
                    active_next     = (cmd_cnt != '0) ? cmd_id : vtgd_pkg::CMD_NONE;
                    pairs_left_next = cmd_cnt;
                end
                else if (cmd_id == vtgd_pkg::CMD_CLOSE_PATH)
                begin
                    active_next     = vtgd_pkg::CMD_NONE;
                    pairs_left_next = '0;
                    if (ring_count_reg >= 32'd3)
                    begin
                        job_next.has_ring    = 1'b1;
                        job_next.ring_close  = 1'b1;
                        job_next.ring_start  = first_index_reg;
                        job_next.ring_points = ring_count_reg;
                        job_next.area_op     = vtgd_pkg::AREA_CLOSE;
                        job_next.a0          = cursor_x_reg;
                        job_next.b0          = first_y_reg;
                        job_next.a1          = first_x_reg;
                        job_next.b1          = cursor_y_reg;
                    end
                    else
                    begin
                        job_next.area_op = vtgd_pkg::AREA_CLEAR;
                    end
                    ring_count_next = '0;
                end
                else
                begin
                    // Unknown command: ignore everything up to the end of the feature.
                    active_next     = vtgd_pkg::CMD_NONE;
                    pairs_left_next = '0;
                    halted_next     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            active_reg        <= vtgd_pkg::CMD_NONE;
            pairs_left_reg    <= '0;
            have_x_reg        <= 1'b0;
            held_x_reg        <= '0;
            first_index_reg   <= '0;
            ring_count_reg    <= '0;
            first_x_reg       <= '0;
            first_y_reg       <= '0;
            halted_reg        <= 1'b0;
            point_counter_reg <= '0;
            job_valid_reg     <= 1'b0;
        end
        else
        begin
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            active_reg        <= active_next;
            pairs_left_reg    <= pairs_left_next;
            have_x_reg        <= have_x_next;
            held_x_reg        <= held_x_next;
            first_index_reg   <= first_index_next;
            ring_count_reg    <= ring_count_next;
            first_x_reg       <= first_x_next;
            first_y_reg       <= first_y_next;
            halted_reg        <= halted_next;
            point_counter_reg <= point_counter_next;
            if (advance)
            begin
                job_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    `VTGD_ASSERT(a_halted_silent,
        (accept && opcode == vtgd_pkg::OP_WORD && halted_reg) |=>
        (!job_reg.has_ring && !job_reg.has_point && !job_reg.has_end),
        "ignored word produced a result")
    `VTGD_ASSERT(a_two_results_max,
        job_valid_reg |-> !(job_reg.has_point && job_reg.has_end),
        "job carries a point and a feature end")
    `VTGD_ASSERT(a_end_clears,
        (accept && opcode == vtgd_pkg::OP_END) |=>
        (cursor_x_reg == '0 && cursor_y_reg == '0 && ring_count_reg == '0 && !halted_reg),
        "feature end left state behind")

endmodule

// File: design/vtgd_area.sv
// ----------------------------------------------------------------------------
// vtgd_area
// Shoelace products, running area sum and assembly of result records.
// ----------------------------------------------------------------------------
module vtgd_area
#(
    parameter int AREA_BITS = vtgd_pkg::AREA_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           job_valid,
    input  vtgd_pkg::job_t job,
    output logic [1:0]     push_count,
    output vtgd_pkg::res_t res0,
    output vtgd_pkg::res_t res1
);

    logic signed [63:0]   prod0;
    logic signed [63:0]   prod1;
    logic                 s2_valid_reg;
    vtgd_pkg::job_t       s2_job_reg;
    logic [AREA_BITS-1:0] p0_reg;
    logic [AREA_BITS-1:0] p1_reg;
    logic [AREA_BITS-1:0] area_reg, area_next;
    logic [AREA_BITS-1:0] sum;
    logic                 ext_close;
    vtgd_pkg::res_t       ring_res;
    vtgd_pkg::res_t       point_res;
    vtgd_pkg::res_t       end_res;

    assign prod0 = $signed(job.a0) * $signed(job.b0);
    assign prod1 = $signed(job.a1) * $signed(job.b1);

    assign sum       = area_reg + p0_reg - p1_reg;
    assign ext_close = (sum != '0) && !sum[AREA_BITS-1];

    always_comb
    begin
        area_next = area_reg;
        case (s2_job_reg.area_op)
            vtgd_pkg::AREA_NONE:  area_next = area_reg;
            vtgd_pkg::AREA_CLEAR: area_next = '0;
            vtgd_pkg::AREA_ADD:   area_next = sum;
            vtgd_pkg::AREA_CLOSE: area_next = '0;
            default:              area_next = area_reg;
        endcase
    end

    always_comb
    begin
        ring_res             = '0;
        ring_res.kind        = vtgd_pkg::KIND_RING;
        ring_res.ring_start  = s2_job_reg.ring_start;
        ring_res.ring_points = s2_job_reg.ring_points;
        ring_res.exterior    = s2_job_reg.ring_close ? ext_close : 1'b1;

        point_res         = '0;
        point_res.kind    = vtgd_pkg::KIND_POINT;
        point_res.point_x = s2_job_reg.px;
        point_res.point_y = s2_job_reg.py;

        end_res      = '0;
        end_res.kind = vtgd_pkg::KIND_END;

        res0       = '0;
        res1       = '0;
        push_count = 2'd0;
        if (s2_job_reg.has_ring)
        begin
            res0 = ring_res;
            if (s2_job_reg.has_point || s2_job_reg.has_end)
            begin
                res1       = s2_job_reg.has_point ? point_res : end_res;
                push_count = 2'd2;
            end
            else
            begin
                push_count = 2'd1;
            end
        end
        else if (s2_job_reg.has_point || s2_job_reg.has_end)
        begin
            res0       = s2_job_reg.has_point ? point_res : end_res;
            push_count = 2'd1;
        end
        if (!(advance && s2_valid_reg))
        begin
            push_count = 2'd0;
        end
        res0.last = (push_count == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            area_reg     <= '0;
        end
        else if (advance)
        begin
            s2_valid_reg <= job_valid;
            if (s2_valid_reg)
            begin
                area_reg <= area_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_job_reg <= job;
            p0_reg     <= prod0[AREA_BITS-1:0];
            p1_reg     <= prod1[AREA_BITS-1:0];
        end
    end

endmodule

// File: design/vtgd_out_fifo.sv
// ----------------------------------------------------------------------------
// vtgd_out_fifo
// Small result queue taking up to two records per cycle and giving one while out_ready is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtgd_out_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     push_count,
    input  vtgd_pkg::res_t wr_data0,
    input  vtgd_pkg::res_t wr_data1,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output vtgd_pkg::res_t out_data
);

    vtgd_pkg::res_t                  mem_reg [vtgd_pkg::OUT_DEPTH];
    logic [vtgd_pkg::OUT_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [vtgd_pkg::OUT_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [vtgd_pkg::OUT_CNT_W-1:0]  count_reg, count_next;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for a full two-record burst.
    assign room      = (count_reg <= vtgd_pkg::OUT_CNT_W'(vtgd_pkg::OUT_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + vtgd_pkg::OUT_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + vtgd_pkg::OUT_PTR_W'(pop);
        count_next  = count_reg + vtgd_pkg::OUT_CNT_W'(push_count)
                      - vtgd_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + vtgd_pkg::OUT_PTR_W'(1)] <= wr_data1;
        end
    end

    // While reset is held the count may not be known yet.
    `VTGD_ASSERT_ALWAYS(a_count_bound,
        !rst_n || (count_reg <= vtgd_pkg::OUT_CNT_W'(vtgd_pkg::OUT_DEPTH)),
        "result queue overfilled")
    `VTGD_ASSERT(a_push_has_room,
        (push_count != 2'd0) |-> room,
        "records pushed without room")

endmodule

// File: design/vector_tile_geometry_decoder_unit.sv
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder_unit
// Streaming decoder of vector tile geometry command words into points,
// ring records and feature ends.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                           | One transaction carries
//  ---------+-----------------------------------+-----------------------------
//  s_axis   | tvalid tready tdata[31:0] tuser   | one geometry word or a
//           |                                   | feature end marker
//  m_axis   | tvalid tready tdata[135:0] tuser  | one point, ring record or
//           | tlast                             | feature end
//
//  One input transaction is taken per cycle while the result queue has room;
//  its results pass the decode register, the product register and the
//  result queue before they leave. The rate is set by the output port: an
//  input that yields two results occupies the output for two transfers.
//  s_axis_tready depends only on the fill level of the four-entry result
//  queue, never combinationally on m_axis_tready.
//  rst_n clears the cursor, ring bookkeeping, area sum, point counter and the
//  queue asynchronously; nothing needs to be swept after reset.
//
module vector_tile_geometry_decoder_unit
#(
    parameter int AREA_BITS = vtgd_pkg::AREA_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] geometry_word
    input  logic [vtgd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] opcode, [2:1] feature_type
    input  logic [vtgd_pkg::IN_TUSER_W-1:0]      s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] ring_start,
    // [127:96] ring_points, [128] exterior, [135:129] zero
    output logic [vtgd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [1:0] kind
    output logic [vtgd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic           advance;
    logic           accept;
    logic           job_valid;
    vtgd_pkg::job_t job;
    logic [1:0]     push_count;
    vtgd_pkg::res_t res0;
    vtgd_pkg::res_t res1;
    vtgd_pkg::res_t out_res;

    // The whole pipeline moves together whenever the result queue can take
    // the largest burst an item may produce (two records).
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    // Decoder: interprets the word against the current command state, moves
    // the cursor and decides which records this transaction causes.
    vtgd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .accept    (accept),
        .opcode    (s_axis_tuser[0]),
        .word      (s_axis_tdata[31:0]),
        .ftype     (s_axis_tuser[2:1]),
        .job_valid (job_valid),
        .job       (job)
    );

    // Area stage: two signed 32x32 products are registered, then folded into
    // the shoelace sum; a closing ring takes its exterior flag from it.
    vtgd_area #(
        .AREA_BITS (AREA_BITS)
    ) u_area
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .job_valid  (job_valid),
        .job        (job),
        .push_count (push_count),
        .res0       (res0),
        .res1       (res1)
    );

    // Result queue: decouples the output handshake from the pipeline.
    vtgd_out_fifo u_out_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .wr_data0   (res0),
        .wr_data1   (res1),
        .room       (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.exterior, out_res.ring_points,
                           out_res.ring_start, out_res.point_y, out_res.point_x};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
